@@ rtl/bpfa_pkg.sv @@
`default_nettype none

package bpfa_pkg;

  // Default sizing of the bitmap and the page
  localparam int unsigned MAX_FRAME_COUNT_DEF  = 65536;
  localparam int unsigned BITMAP_WORD_BITS_DEF = 32;
  localparam int unsigned PAGE_SHIFT_DEF       = 12;

  // Fixed field widths
  localparam int unsigned ADDR_W      = 32;
  localparam int unsigned KIB_W       = 22;
  localparam int unsigned KIB_SHIFT   = 10;
  localparam int unsigned OP_W        = 2;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned COUNT_OUT_W = 17;
  localparam int unsigned CFG_IDX_W   = 2;

  // Output stream packing: frame_address, free_count, total_count, zero fill
  localparam int unsigned OUT_FIELDS_W = ADDR_W + 2 * COUNT_OUT_W;
  localparam int unsigned OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int unsigned OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

  // Memory map facts
  localparam logic [ADDR_W-1:0] LOW_MEMORY_BYTES = 32'h0010_0000;
  localparam logic [ADDR_W-1:0] KSTART_RESET     = 32'h0010_0000;
  localparam logic [ADDR_W-1:0] KEND_RESET       = 32'h0020_0000;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MEM_SIZE_KIB = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_START = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_END   = 2'd2;

  typedef enum logic [OP_W-1:0] {
    OP_INIT  = 2'd0,
    OP_ALLOC = 2'd1,
    OP_FREE  = 2'd2
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE         = 2'd0,
    ST_NO_MEMORY    = 2'd1,
    ST_FREE_IGNORED = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_INIT_SWEEP,
    S_INIT_FIN,
    S_ALLOC_SCAN,
    S_ALLOC_WR,
    S_FREE_CHK,
    S_RESP
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic    latch_in;
    logic    init_start;
    logic    sweep_en;
    logic    init_finish;
    logic    scan_start;
    logic    scan_en;
    logic    alloc_commit;
    logic    free_rd;
    logic    free_commit;
    logic    resp_load;
    status_e status;
  } bpfa_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            sweep_last;
    logic            scan_hit;
    logic            scan_miss;
    logic            free_in_range;
    logic            free_bit_set;
    logic            out_busy;
  } bpfa_stat_t;

endpackage

`default_nettype wire

@@ rtl/bpfa_ram.sv @@
`default_nettype none

module bpfa_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 2048,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ rtl/bpfa_ctrl.sv @@
`default_nettype none

module bpfa_ctrl import bpfa_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  bpfa_stat_t stat_i,
  output bpfa_cmd_t  cmd_o
);

  state_e  state_q, state_d;
  status_e status_q, status_d;

  // State and pending status
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      status_q <= ST_DONE;
    end else begin
      state_q  <= state_d;
      status_q <= status_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d       = state_q;
    status_d      = status_q;
    in_ready_o    = 1'b0;
    cmd_o         = '0;
    cmd_o.status  = status_q;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch_in = 1'b1;
          state_d        = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (stat_i.op)
          OP_INIT: begin
            cmd_o.init_start = 1'b1;
            state_d          = S_INIT_SWEEP;
          end
          OP_ALLOC: begin
            cmd_o.scan_start = 1'b1;
            state_d          = S_ALLOC_SCAN;
          end
          OP_FREE: begin
            if (stat_i.free_in_range) begin
              cmd_o.free_rd = 1'b1;
              state_d       = S_FREE_CHK;
            end else begin
              status_d = ST_FREE_IGNORED;
              state_d  = S_RESP;
            end
          end
          default: begin
            status_d = ST_DONE;
            state_d  = S_RESP;
          end
        endcase
      end
      S_INIT_SWEEP: begin
        cmd_o.sweep_en = 1'b1;
        if (stat_i.sweep_last) begin
          state_d = S_INIT_FIN;
        end
      end
      S_INIT_FIN: begin
        cmd_o.init_finish = 1'b1;
        status_d          = ST_DONE;
        state_d           = S_RESP;
      end
      S_ALLOC_SCAN: begin
        cmd_o.scan_en = 1'b1;
        if (stat_i.scan_hit) begin
          state_d = S_ALLOC_WR;
        end else if (stat_i.scan_miss) begin
          status_d = ST_NO_MEMORY;
          state_d  = S_RESP;
        end
      end
      S_ALLOC_WR: begin
        cmd_o.alloc_commit = 1'b1;
        status_d           = ST_DONE;
        state_d            = S_RESP;
      end
      S_FREE_CHK: begin
        if (stat_i.free_bit_set) begin
          cmd_o.free_commit = 1'b1;
          status_d          = ST_DONE;
        end else begin
          status_d = ST_FREE_IGNORED;
        end
        state_d = S_RESP;
      end
      S_RESP: begin
        if (!stat_i.out_busy) begin
          cmd_o.resp_load = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/bpfa_dp.sv @@
`default_nettype none

module bpfa_dp import bpfa_pkg::*; #(
  parameter int unsigned MAX_FRAME_COUNT  = MAX_FRAME_COUNT_DEF,
  parameter int unsigned BITMAP_WORD_BITS = BITMAP_WORD_BITS_DEF,
  parameter int unsigned PAGE_SHIFT       = PAGE_SHIFT_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  bpfa_cmd_t              cmd_i,
  output bpfa_stat_t             stat_o,
  input  logic [OP_W-1:0]        in_op_i,
  input  logic [ADDR_W-1:0]      in_addr_i,
  input  logic                   cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [ADDR_W-1:0]      cfg_data_i,
  input  logic                   out_ready_i,
  output logic                   out_valid_o,
  output logic [STATUS_W-1:0]    out_status_o,
  output logic [ADDR_W-1:0]      out_faddr_o,
  output logic [COUNT_OUT_W-1:0] out_free_o,
  output logic [COUNT_OUT_W-1:0] out_total_o
);

  // Word size is a power of two: frame = {word index, bit index}
  localparam int unsigned WB         = BITMAP_WORD_BITS;
  localparam int unsigned LOG_WB     = $clog2(WB);
  localparam int unsigned WORD_COUNT = (MAX_FRAME_COUNT + WB - 1) / WB;
  localparam int unsigned WADDR_W    = $clog2(WORD_COUNT);
  localparam int unsigned WCNT_W     = WADDR_W + 1;
  localparam int unsigned CNT_W      = $clog2(MAX_FRAME_COUNT + 1);
  localparam int unsigned CMP_W      = ADDR_W + 1;
  localparam int unsigned LOW_FRAME  = LOW_MEMORY_BYTES >> PAGE_SHIFT;

  // Configuration registers
  logic [KIB_W-1:0]  mem_kib_q;
  logic [ADDR_W-1:0] kstart_q;
  logic [ADDR_W-1:0] kend_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mem_kib_q <= '0;
      kstart_q  <= KSTART_RESET;
      kend_q    <= KEND_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_MEM_SIZE_KIB: mem_kib_q <= cfg_data_i[KIB_W-1:0];
        CFG_KERNEL_START: kstart_q  <= cfg_data_i;
        CFG_KERNEL_END:   kend_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Latched input item
  logic [OP_W-1:0]   op_q;
  logic [ADDR_W-1:0] addr_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      op_q   <= in_op_i;
      addr_q <= in_addr_i;
    end
  end

  // Frame count from memory size, clamped to capacity
  logic [ADDR_W-1:0] kib_bytes;
  logic [ADDR_W-1:0] n_raw;
  logic [CNT_W-1:0]  n_new;

  assign kib_bytes = {mem_kib_q, {KIB_SHIFT{1'b0}}};
  assign n_raw     = kib_bytes >> PAGE_SHIFT;
  assign n_new     = (n_raw > ADDR_W'(MAX_FRAME_COUNT)) ? CNT_W'(MAX_FRAME_COUNT)
                                                        : n_raw[CNT_W-1:0];

  // Kernel range in frames, end rounded up and clamped to the bitmap
  logic [CMP_W-1:0] ks_w;
  logic [CMP_W-1:0] kend_sum;
  logic [CMP_W-1:0] ke_raw;
  logic [CMP_W-1:0] ke_w;
  logic [CMP_W-1:0] low_w;

  assign ks_w     = CMP_W'(kstart_q >> PAGE_SHIFT);
  assign kend_sum = CMP_W'(kend_q) + CMP_W'((2 ** PAGE_SHIFT) - 1);
  assign ke_raw   = kend_sum >> PAGE_SHIFT;
  assign ke_w     = (ke_raw >= CMP_W'(MAX_FRAME_COUNT)) ? CMP_W'(MAX_FRAME_COUNT - 1) : ke_raw;
  assign low_w    = CMP_W'(LOW_FRAME);

  // Counters
  logic [CNT_W-1:0] n_q;
  logic [CNT_W-1:0] used_q;
  logic [CMP_W-1:0] n_w;

  assign n_w = CMP_W'(n_q);

  // Free-frame count of a fresh init, two register stages behind n_q;
  // it settles long before the sweep ends
  logic             n_gt_low_q;
  logic [CNT_W-1:0] span_q;
  logic [CMP_W-1:0] lo_b_q;
  logic [CMP_W-1:0] hi_b_q;
  logic [CNT_W-1:0] ov_q;

  always_ff @(posedge clk_i) begin
    n_gt_low_q <= n_w > low_w;
    span_q     <= (n_w > low_w) ? n_q - CNT_W'(LOW_FRAME) : '0;
    lo_b_q     <= (ks_w > low_w) ? ks_w : low_w;
    hi_b_q     <= (ke_w < n_w - CMP_W'(1)) ? ke_w : n_w - CMP_W'(1);
    ov_q       <= (n_gt_low_q && hi_b_q >= lo_b_q) ? CNT_W'(hi_b_q - lo_b_q + CMP_W'(1))
                                                   : '0;
  end

  // RAM port signals
  logic               ram_we;
  logic [WADDR_W-1:0] ram_waddr;
  logic [WB-1:0]      ram_wdata;
  logic               ram_re;
  logic [WADDR_W-1:0] ram_raddr;
  logic [WB-1:0]      rdata;

  // Init sweep: one bitmap word per cycle
  logic [WADDR_W-1:0] sweep_q;
  logic [WB-1:0]      init_word;

  always_ff @(posedge clk_i) begin
    if (cmd_i.init_start) begin
      sweep_q <= '0;
    end else if (cmd_i.sweep_en) begin
      sweep_q <= sweep_q + WADDR_W'(1);
    end
  end

  always_comb begin
    logic [CMP_W-1:0] fr;
    fr        = '0;
    init_word = '1;
    for (int i = 0; i < int'(WB); i++) begin
      fr           = CMP_W'({sweep_q, LOG_WB'(i)});
      init_word[i] = !((fr >= low_w) && (fr < n_w) && !((fr >= ks_w) && (fr <= ke_w)));
    end
  end

  // First-fit scan: read pipeline, one word issued per cycle
  logic [WCNT_W-1:0]  rd_addr_q;
  logic               chk_valid_q;
  logic [WADDR_W-1:0] chk_addr_q;
  logic               issue_ok;
  logic               scan_issue;
  logic [LOG_WB-1:0]  zero_idx;
  logic               scan_hit;

  assign issue_ok   = CMP_W'({rd_addr_q, {LOG_WB{1'b0}}}) < n_w;
  assign scan_issue = cmd_i.scan_en && issue_ok;
  assign scan_hit   = chk_valid_q && !(&rdata);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chk_valid_q <= 1'b0;
    end else begin
      chk_valid_q <= scan_issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_start) begin
      rd_addr_q <= '0;
    end else if (scan_issue) begin
      rd_addr_q <= rd_addr_q + WCNT_W'(1);
    end
    chk_addr_q <= rd_addr_q[WADDR_W-1:0];
  end

  // Lowest clear bit of the checked word
  always_comb begin
    zero_idx = '0;
    for (int i = int'(WB) - 1; i >= 0; i--) begin
      if (!rdata[i]) begin
        zero_idx = LOG_WB'(i);
      end
    end
  end

  logic [WADDR_W-1:0] hit_addr_q;
  logic [LOG_WB-1:0]  hit_bit_q;
  logic [WB-1:0]      hit_word_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_en && scan_hit) begin
      hit_addr_q <= chk_addr_q;
      hit_bit_q  <= zero_idx;
      hit_word_q <= rdata | (WB'(1) << zero_idx);
    end
  end

  // Free path
  logic [ADDR_W-1:0]  free_frame;
  logic [WADDR_W-1:0] free_waddr;
  logic [LOG_WB-1:0]  free_bit;
  logic               free_in_range;
  logic               free_bit_set;

  assign free_frame    = addr_q >> PAGE_SHIFT;
  assign free_waddr    = free_frame[WADDR_W+LOG_WB-1:LOG_WB];
  assign free_bit      = free_frame[LOG_WB-1:0];
  assign free_in_range = CMP_W'(free_frame) < n_w;
  assign free_bit_set  = rdata[free_bit] && (used_q != '0);

  // Bitmap memory
  assign ram_re    = scan_issue || cmd_i.free_rd;
  assign ram_raddr = cmd_i.free_rd ? free_waddr : rd_addr_q[WADDR_W-1:0];
  assign ram_we    = cmd_i.sweep_en || cmd_i.alloc_commit || cmd_i.free_commit;

  always_comb begin
    ram_waddr = sweep_q;
    ram_wdata = init_word;
    if (cmd_i.alloc_commit) begin
      ram_waddr = hit_addr_q;
      ram_wdata = hit_word_q;
    end else if (cmd_i.free_commit) begin
      ram_waddr = free_waddr;
      ram_wdata = rdata & ~(WB'(1) << free_bit);
    end
  end

  bpfa_ram #(
    .WIDTH (WB),
    .DEPTH (WORD_COUNT)
  ) u_bitmap (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (rdata)
  );

  // Frame and used counts
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q    <= '0;
      used_q <= '0;
    end else begin
      if (cmd_i.init_start) begin
        n_q <= n_new;
      end
      if (cmd_i.init_finish) begin
        used_q <= n_q - span_q + ov_q;
      end else if (cmd_i.alloc_commit) begin
        used_q <= used_q + CNT_W'(1);
      end else if (cmd_i.free_commit) begin
        used_q <= used_q - CNT_W'(1);
      end
    end
  end

  // Allocated frame address
  logic [ADDR_W-1:0] faddr_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      faddr_q <= '0;
    end else if (cmd_i.alloc_commit) begin
      faddr_q <= ADDR_W'({hit_addr_q, hit_bit_q, {PAGE_SHIFT{1'b0}}});
    end
  end

  // Output register
  logic                   out_valid_q;
  logic [STATUS_W-1:0]    out_status_q;
  logic [ADDR_W-1:0]      out_faddr_q;
  logic [COUNT_OUT_W-1:0] out_free_q;
  logic [COUNT_OUT_W-1:0] out_total_q;
  logic [CNT_W-1:0]       free_cnt;

  assign free_cnt = (n_q >= used_q) ? n_q - used_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.resp_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.resp_load) begin
      out_status_q <= cmd_i.status;
      out_faddr_q  <= faddr_q;
      out_free_q   <= COUNT_OUT_W'(free_cnt);
      out_total_q  <= COUNT_OUT_W'(n_q);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_faddr_o  = out_faddr_q;
  assign out_free_o   = out_free_q;
  assign out_total_o  = out_total_q;

  // Status to controller
  assign stat_o.op            = op_q;
  assign stat_o.sweep_last    = sweep_q == WADDR_W'(WORD_COUNT - 1);
  assign stat_o.scan_hit      = scan_hit;
  assign stat_o.scan_miss     = !chk_valid_q && !issue_ok;
  assign stat_o.free_in_range = free_in_range;
  assign stat_o.free_bit_set  = free_bit_set;
  assign stat_o.out_busy      = out_valid_q && !out_ready_i;

  // Allocated frame always lies below the frame count
  a_alloc_below_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.alloc_commit |-> (CMP_W'({hit_addr_q, hit_bit_q}) < n_w))
    else $error("allocated frame beyond frame count");

  // A free never takes the used count below zero
  a_free_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.free_commit |-> (used_q != '0))
    else $error("free with zero used count");

  // Reported counts are consistent
  a_used_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.resp_load |-> (used_q <= n_q))
    else $error("used count exceeds frame count");

endmodule

`default_nettype wire

@@ rtl/bitmap_page_frame_allocator_top.sv @@
`default_nettype none

// Channel  Direction  Handshake                    Payload
// s_axis   in         s_axis_tvalid/s_axis_tready  tuser: op; tdata: free_address
// m_axis   out        m_axis_tvalid/m_axis_tready  tuser: status;
//                                                  tdata: frame_address, free_count,
//                                                  total_count
// cfg      in         cfg_valid_i/cfg_ready_o      cfg_index_i, cfg_data_i
//
// One item at a time; a new item is taken while the previous result waits.
// Init: one bitmap word written per cycle over all words (2048 by default).
// Allocate: the first-fit scan reads one word per cycle up to the frame count.
// Free: the bit is checked, then cleared; an out-of-range frame skips both.
// A stalled output holds the result and the next.
// Reset leaves no frame under management; the bitmap is rebuilt by init, no clear pass.

module bitmap_page_frame_allocator_top import bpfa_pkg::*; #(
  parameter int unsigned MAX_FRAME_COUNT  = MAX_FRAME_COUNT_DEF,
  parameter int unsigned BITMAP_WORD_BITS = BITMAP_WORD_BITS_DEF,
  parameter int unsigned PAGE_SHIFT       = PAGE_SHIFT_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [ADDR_W-1:0]      s_axis_tdata,   // [31:0] free_address
  input  logic [OP_W-1:0]        s_axis_tuser,   // [1:0] op
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [31:0] frame_address,
                                                 // [48:32] free_count,
                                                 // [65:49] total_count, [71:66] zero
  output logic [STATUS_W-1:0]    m_axis_tuser,   // [1:0] status
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [ADDR_W-1:0]      cfg_data_i
);

  bpfa_cmd_t              cmd;
  bpfa_stat_t             stat;
  logic [ADDR_W-1:0]      out_faddr;
  logic [COUNT_OUT_W-1:0] out_free;
  logic [COUNT_OUT_W-1:0] out_total;

  bpfa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  bpfa_dp #(
    .MAX_FRAME_COUNT  (MAX_FRAME_COUNT),
    .BITMAP_WORD_BITS (BITMAP_WORD_BITS),
    .PAGE_SHIFT       (PAGE_SHIFT)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .in_op_i      (s_axis_tuser),
    .in_addr_i    (s_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_status_o (m_axis_tuser),
    .out_faddr_o  (out_faddr),
    .out_free_o   (out_free),
    .out_total_o  (out_total)
  );

  // Registers are always writable
  assign cfg_ready_o = 1'b1;

  // Pack result fields, lowest first
  assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, out_total, out_free, out_faddr};

endmodule

`default_nettype wire
